### design/prwht_pkg.sv
// Shared constants, codes and types of the photon random-walk heat tally.
package prwht_pkg;

    localparam int SHELL_COUNT_DEF = 241;
    localparam int RAND_W          = 16;
    localparam int DIV_W           = 47;

    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam logic [32:0] LN2_Q32 = 33'd2977044472;

    localparam logic [23:0] ALBEDO_RST    = 24'd16687733;
    localparam logic [23:0] SHELLS_RST    = 24'd25072;
    localparam logic [30:0] THRESHOLD_RST = 31'd1073742;
    localparam logic [15:0] CHANCE_RST    = 16'd6554;

    localparam logic [1:0] REG_ALBEDO    = 2'd0;
    localparam logic [1:0] REG_SHELLS    = 2'd1;
    localparam logic [1:0] REG_THRESHOLD = 2'd2;
    localparam logic [1:0] REG_CHANCE    = 2'd3;

    typedef enum logic [1:0] {
        CMD_LAUNCH  = 2'd0,
        CMD_HOP     = 2'd1,
        CMD_SCATTER = 2'd2,
        CMD_READ    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_RETRY = 2'd1,
        ST_ENDED = 2'd2,
        ST_BIN   = 2'd3
    } status_t;

    typedef enum logic {
        IM_SQRT = 1'b0,
        IM_DIV  = 1'b1
    } iter_mode_t;

    typedef struct packed {
        logic       start;
        iter_mode_t mode;
    } iter_req_t;

endpackage

### design/prwht_mul.sv
// Shared registered signed 33x33 multiplier.
module prwht_mul
(
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    output logic signed [65:0] p
);

    logic signed [65:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

### design/prwht_iter.sv
// Shared compare-subtract unit: bitwise square root and restoring division.
module prwht_iter
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  prwht_pkg::iter_req_t  req,
    input  logic [63:0]           operand,
    input  logic [15:0]           divisor,
    output logic                  done,
    output logic [63:0]           result
);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    prwht_pkg::iter_mode_t mode_reg, mode_next;
    logic [5:0]            cnt_reg, cnt_next;
    logic [63:0]           n_reg, n_next;
    logic [63:0]           res_reg, res_next;
    logic [63:0]           bit_reg, bit_next;
    logic [15:0]           div_reg, div_next;
    logic [64:0]           cmp_a, cmp_b, diff;
    logic                  ge;
    logic [5:0]            last;

    always_comb
    begin
        if (mode_reg == prwht_pkg::IM_SQRT)
        begin
            cmp_a = {1'b0, n_reg};
            cmp_b = {1'b0, res_reg} + {1'b0, bit_reg};
            last  = 6'd31;
        end
        else
        begin
            cmp_a = {res_reg, n_reg[63]};
            cmp_b = {49'b0, div_reg};
            last  = 6'(prwht_pkg::DIV_W - 1);
        end
        diff = cmp_a - cmp_b;
        ge   = (cmp_a >= cmp_b);
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            mode_next = req.mode;
            cnt_next  = 6'd0;
            res_next  = 64'd0;
            bit_next  = 64'd1 << 62;
            div_next  = divisor;
            if (req.mode == prwht_pkg::IM_SQRT)
                n_next = operand;
            else
                n_next = operand << (64 - prwht_pkg::DIV_W);
        end
        else if (busy_reg)
        begin
            if (mode_reg == prwht_pkg::IM_SQRT)
            begin
                if (ge)
                begin
                    n_next   = diff[63:0];
                    res_next = (res_reg >> 1) + bit_reg;
                end
                else
                begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
            end
            else
            begin
                if (ge)
                begin
                    res_next = diff[63:0];
                    n_next   = {n_reg[62:0], 1'b1};
                end
                else
                begin
                    res_next = cmp_a[63:0];
                    n_next   = {n_reg[62:0], 1'b0};
                end
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= prwht_pkg::IM_SQRT;
            cnt_reg  <= 6'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg   <= n_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        div_reg <= div_next;
    end

    assign done   = done_reg;
    assign result = (mode_reg == prwht_pkg::IM_SQRT) ? res_reg : n_reg;

endmodule

### design/prwht_heat_mem.sv
// Heat bin memory with a clearing pass after reset and a registered read port.
module prwht_heat_mem #(
    parameter int DEPTH  = prwht_pkg::SHELL_COUNT_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [62:0]       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [62:0]       wr_data,
    output logic              clearing
);

    logic [62:0]       mem [DEPTH];
    logic [62:0]       rd_data_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                clearing_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
            mem[clr_cnt_reg] <= '0;
        else if (wr_en)
            mem[wr_addr] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data  = rd_data_reg;
    assign clearing = clearing_reg;

endmodule

### design/photon_random_walk_heat_tally.sv
// Top level: command sequencer of the photon random-walk engine with heat tally.
//
// Requests enter on the s_axis channel: tuser carries the command (launch, hop,
// scatter with roulette, read bin), tdata the random samples and the bin index.
// Each request gives one result on m_axis: tuser is the status, tdata the shell
// hit, the bin value and the weight after the step. Registers are set through
// cfg_we/cfg_index/cfg_wdata; the user must set them only while no request is
// in flight, which the block itself does not enforce. One request is worked at
// a time on a shared 33x33 multiplier and a shared compare-subtract unit. A hop
// runs the log squaring, the multiply steps, the square-root steps and a bin
// read-modify-write; a scatter adds a division when roulette divides. The
// square-root and divide loops are the longest steps.
// After reset the heat memory is zeroed, one bin a cycle until all SHELL_COUNT
// bins are clear, with s_axis_tready low. A finished result sits in the output
// register; the next request is taken meanwhile, and its result waits while
// m_axis_tready is low.
module photon_random_walk_heat_tally #(
    parameter int SHELL_COUNT = prwht_pkg::SHELL_COUNT_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [55:0]   s_axis_tdata,  // rand_a, rand_b, rand_c, bin_index
    input  logic [1:0]    s_axis_tuser,  // command
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [103:0]  m_axis_tdata,  // shell_hit, bin_value, weight_now, zero pad
    output logic [1:0]    m_axis_tuser,  // status
    input  logic          cfg_we,
    input  logic [1:0]    cfg_index,
    input  logic [30:0]   cfg_wdata
);

    localparam int ADDR_W = $clog2(SHELL_COUNT);
    localparam logic [ADDR_W-1:0] LAST_SHELL = ADDR_W'(SHELL_COUNT - 1);

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_LOG   = 10'b00_0000_0010,
        S_HOP   = 10'b00_0000_0100,
        S_SQRT  = 10'b00_0000_1000,
        S_HOP2  = 10'b00_0001_0000,
        S_SCAT  = 10'b00_0010_0000,
        S_SCAT2 = 10'b00_0100_0000,
        S_DIV   = 10'b00_1000_0000,
        S_READ  = 10'b01_0000_0000,
        S_DONE  = 10'b10_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;

    logic [23:0] albedo_reg, shells_reg;
    logic [30:0] threshold_reg;
    logic [15:0] chance_reg;

    logic signed [31:0] pos_x_reg, pos_x_next, pos_y_reg, pos_y_next, pos_z_reg, pos_z_next;
    logic signed [31:0] dir_u_reg, dir_u_next, dir_v_reg, dir_v_next, dir_w_reg, dir_w_next;
    logic [30:0] weight_reg, weight_next;

    prwht_pkg::cmd_t cmd_reg, cmd_next;
    logic [15:0] rc_reg, rc_next;
    logic [7:0]  bin_reg, bin_next;
    logic [4:0]  e_reg, e_next;
    logic [30:0] y_reg, y_next;
    logic [23:0] frac_reg, frac_next;
    logic [20:0] t_reg, t_next;
    logic [63:0] acc_reg, acc_next;
    logic [30:0] nw_reg, nw_next;
    logic signed [31:0] x1_reg, x1_next, x2_reg, x2_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] root_reg, root_next;
    logic [ADDR_W-1:0] shell_reg, shell_next;

    prwht_pkg::status_t res_status_reg, res_status_next;
    logic [7:0]  res_shell_reg, res_shell_next;
    logic [62:0] res_bin_reg, res_bin_next;

    logic        out_valid_reg, out_valid_next;
    prwht_pkg::status_t out_status_reg;
    logic [7:0]  out_shell_reg;
    logic [62:0] out_bin_reg;
    logic [30:0] out_weight_reg;
    logic        out_load;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;

    prwht_pkg::iter_req_t iter_req;
    logic [63:0] iter_operand, iter_result;
    logic        iter_done;

    logic [ADDR_W-1:0] mem_rd_addr, mem_wr_addr;
    logic [62:0] mem_rd_data, mem_wr_data;
    logic        mem_wr_en, mem_clearing;

    logic        in_accept;
    logic [15:0] in_ra, in_rb;
    logic [16:0] m_val;
    logic [4:0]  e_init;
    logic [63:0] xa_tmp, xb_tmp;
    logic [33:0] yy;
    logic        ybit;
    logic [30:0] ynorm;
    logic [28:0] len;
    logic [61:0] t_sum;
    logic [63:0] s_sum;
    logic [31:0] shell_raw;
    logic [ADDR_W-1:0] shell_clamp;
    logic [63:0] heat_sum;
    logic [30:0] dep;
    logic [46:0] quot;

    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        if (v > 66'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (v < -66'sd2147483648)
            return 32'sh8000_0000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] move(input logic signed [31:0] pos,
                                                input logic signed [65:0] prod);
        logic signed [65:0] step;
        step = (prod + (66'sd1 <<< 29)) >>> 30;
        return sat32({{34{pos[31]}}, pos} + step);
    endfunction

    function automatic logic signed [31:0] turn(input logic signed [65:0] prod);
        return sat32((prod + (66'sd1 <<< 28)) >>> 29);
    endfunction

    prwht_mul u_mul
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    prwht_iter u_iter
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (iter_req),
        .operand (iter_operand),
        .divisor (chance_reg),
        .done    (iter_done),
        .result  (iter_result)
    );

    prwht_heat_mem #(
        .DEPTH  (SHELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_heat_mem
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_addr  (mem_rd_addr),
        .rd_data  (mem_rd_data),
        .wr_en    (mem_wr_en),
        .wr_addr  (mem_wr_addr),
        .wr_data  (mem_wr_data),
        .clearing (mem_clearing)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !mem_clearing;
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign in_ra         = s_axis_tdata[15:0];
    assign in_rb         = s_axis_tdata[31:16];

    always_comb
    begin
        m_val  = {1'b0, in_ra} + 17'd1;
        e_init = 5'd0;
        for (int i = 0; i < 17; i++)
        begin
            if (m_val[i])
                e_init = 5'(i);
        end
        xa_tmp = (64'({in_ra, 1'b1}) << 30) >> prwht_pkg::RAND_W;
        xb_tmp = (64'({in_rb, 1'b1}) << 30) >> prwht_pkg::RAND_W;
        yy     = mul_p[63:30];
        ybit   = yy[31];
        ynorm  = ybit ? yy[31:1] : yy[30:0];
        len    = (29'(prwht_pkg::RAND_W) << 24) - {e_reg, frac_reg};
        t_sum  = mul_p[61:0] + (62'd1 << 39);
        s_sum  = acc_reg + mul_p[63:0];
        shell_raw   = mul_p[63:32];
        shell_clamp = (shell_raw > 32'(SHELL_COUNT - 1)) ? LAST_SHELL : ADDR_W'(shell_raw);
        dep      = weight_reg - nw_reg;
        heat_sum = {1'b0, mem_rd_data} + 64'(dep);
        quot     = iter_result[46:0];
    end

    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        pos_z_next      = pos_z_reg;
        dir_u_next      = dir_u_reg;
        dir_v_next      = dir_v_reg;
        dir_w_next      = dir_w_reg;
        weight_next     = weight_reg;
        cmd_next        = cmd_reg;
        rc_next         = rc_reg;
        bin_next        = bin_reg;
        e_next          = e_reg;
        y_next          = y_reg;
        frac_next       = frac_reg;
        t_next          = t_reg;
        acc_next        = acc_reg;
        nw_next         = nw_reg;
        x1_next         = x1_reg;
        x2_next         = x2_reg;
        s_next          = s_reg;
        root_next       = root_reg;
        shell_next      = shell_reg;
        res_status_next = res_status_reg;
        res_shell_next  = res_shell_reg;
        res_bin_next    = res_bin_reg;
        mul_a           = '0;
        mul_b           = '0;
        iter_req.start  = 1'b0;
        iter_req.mode   = prwht_pkg::IM_SQRT;
        iter_operand    = acc_reg;
        mem_rd_addr     = ADDR_W'(bin_reg);
        mem_wr_en       = 1'b0;
        mem_wr_addr     = shell_reg;
        mem_wr_data     = heat_sum[63] ? {63{1'b1}} : heat_sum[62:0];
        out_load        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    cmd_next        = prwht_pkg::cmd_t'(s_axis_tuser);
                    rc_next         = s_axis_tdata[47:32];
                    bin_next        = s_axis_tdata[55:48];
                    e_next          = e_init;
                    y_next          = 31'({14'b0, m_val} << (5'd30 - e_init));
                    x1_next         = 32'(xa_tmp) - 32'(prwht_pkg::ONE_Q30);
                    x2_next         = 32'(xb_tmp) - 32'(prwht_pkg::ONE_Q30);
                    cnt_next        = 5'd0;
                    res_status_next = prwht_pkg::ST_DONE;
                    res_shell_next  = 8'd0;
                    res_bin_next    = 63'd0;
                    case (prwht_pkg::cmd_t'(s_axis_tuser))
                        prwht_pkg::CMD_LAUNCH:
                        begin
                            pos_x_next  = '0;
                            pos_y_next  = '0;
                            pos_z_next  = '0;
                            dir_u_next  = '0;
                            dir_v_next  = '0;
                            dir_w_next  = 32'(prwht_pkg::ONE_Q30);
                            weight_next = prwht_pkg::ONE_Q30;
                            state_next  = S_DONE;
                        end
                        prwht_pkg::CMD_HOP:     state_next = S_LOG;
                        prwht_pkg::CMD_SCATTER: state_next = S_SCAT;
                        default:                state_next = S_READ;
                    endcase
                end
            end

            S_LOG:
            begin
                mul_a = {2'b0, (cnt_reg == 5'd0) ? y_reg : ynorm};
                mul_b = mul_a;
                if (cnt_reg != 5'd0)
                    frac_next = {frac_reg[22:0], ybit};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd24)
                begin
                    cnt_next   = 5'd0;
                    state_next = S_HOP;
                end
            end

            S_HOP:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        mul_a = {4'b0, len};
                        mul_b = prwht_pkg::LN2_Q32;
                    end
                    5'd1:
                    begin
                        t_next = t_sum[60:40];
                    end
                    5'd2:
                    begin
                        mul_a = {12'b0, t_reg};
                        mul_b = {dir_u_reg[31], dir_u_reg};
                    end
                    5'd3:
                    begin
                        pos_x_next = move(pos_x_reg, mul_p);
                        mul_a = {12'b0, t_reg};
                        mul_b = {dir_v_reg[31], dir_v_reg};
                    end
                    5'd4:
                    begin
                        pos_y_next = move(pos_y_reg, mul_p);
                        mul_a = {12'b0, t_reg};
                        mul_b = {dir_w_reg[31], dir_w_reg};
                    end
                    5'd5:
                    begin
                        pos_z_next = move(pos_z_reg, mul_p);
                    end
                    5'd6:
                    begin
                        mul_a = {pos_x_reg[31], pos_x_reg};
                        mul_b = mul_a;
                    end
                    5'd7:
                    begin
                        acc_next = mul_p[63:0];
                        mul_a = {pos_y_reg[31], pos_y_reg};
                        mul_b = mul_a;
                    end
                    5'd8:
                    begin
                        acc_next = s_sum;
                        mul_a = {pos_z_reg[31], pos_z_reg};
                        mul_b = mul_a;
                    end
                    5'd9:
                    begin
                        acc_next = s_sum;
                        mul_a = {2'b0, weight_reg};
                        mul_b = {9'b0, albedo_reg};
                    end
                    default:
                    begin
                        nw_next        = mul_p[54:24];
                        iter_req.start = 1'b1;
                        iter_operand   = acc_reg;
                        cnt_next       = 5'd0;
                        state_next     = S_SQRT;
                    end
                endcase
            end

            S_SQRT:
            begin
                if (iter_done)
                begin
                    root_next  = iter_result[31:0];
                    cnt_next   = 5'd0;
                    state_next = (cmd_reg == prwht_pkg::CMD_HOP) ? S_HOP2 : S_SCAT2;
                end
            end

            S_HOP2:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        mul_a = {1'b0, root_reg};
                        mul_b = {9'b0, shells_reg};
                    end
                    5'd1:
                    begin
                        shell_next  = shell_clamp;
                        mem_rd_addr = shell_clamp;
                    end
                    default:
                    begin
                        mem_wr_en      = 1'b1;
                        weight_next    = nw_reg;
                        res_shell_next = 8'(shell_reg);
                        state_next     = S_DONE;
                    end
                endcase
            end

            S_SCAT:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        mul_a = {x1_reg[31], x1_reg};
                        mul_b = mul_a;
                    end
                    5'd1:
                    begin
                        acc_next = mul_p[63:0];
                        mul_a = {x2_reg[31], x2_reg};
                        mul_b = mul_a;
                    end
                    5'd2:
                    begin
                        s_next = s_sum[61:30];
                    end
                    default:
                    begin
                        if (s_reg > 32'(prwht_pkg::ONE_Q30))
                        begin
                            res_status_next = prwht_pkg::ST_RETRY;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            iter_req.start = 1'b1;
                            iter_operand   = 64'(prwht_pkg::ONE_Q30 - s_reg[30:0]) << 30;
                            state_next     = S_SQRT;
                        end
                    end
                endcase
            end

            S_SCAT2:
            begin
                cnt_next = cnt_reg + 5'd1;
                case (cnt_reg)
                    5'd0:
                    begin
                        mul_a = {x1_reg[31], x1_reg};
                        mul_b = {1'b0, root_reg};
                    end
                    5'd1:
                    begin
                        dir_v_next = turn(mul_p);
                        mul_a = {x2_reg[31], x2_reg};
                        mul_b = {1'b0, root_reg};
                    end
                    default:
                    begin
                        dir_w_next = turn(mul_p);
                        dir_u_next = {s_reg[30:0], 1'b0} - 32'(prwht_pkg::ONE_Q30);
                        state_next = S_DONE;
                        if (weight_reg < threshold_reg)
                        begin
                            if (rc_reg < chance_reg)
                            begin
                                iter_req.start = 1'b1;
                                iter_req.mode  = prwht_pkg::IM_DIV;
                                iter_operand   = 64'({weight_reg, 16'b0});
                                state_next     = S_DIV;
                            end
                            else
                            begin
                                weight_next     = '0;
                                res_status_next = prwht_pkg::ST_ENDED;
                            end
                        end
                    end
                endcase
            end

            S_DIV:
            begin
                if (iter_done)
                begin
                    weight_next = (quot > 47'(prwht_pkg::ONE_Q30)) ? prwht_pkg::ONE_Q30
                                                                   : quot[30:0];
                    state_next  = S_DONE;
                end
            end

            S_READ:
            begin
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg != 5'd0)
                begin
                    res_status_next = prwht_pkg::ST_BIN;
                    res_bin_next    = (16'(bin_reg) < 16'(SHELL_COUNT)) ? mem_rd_data : 63'd0;
                    state_next      = S_DONE;
                end
            end

            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        out_valid_next = (out_valid_reg && !m_axis_tready) || out_load;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= 5'd0;
            out_valid_reg <= 1'b0;
            pos_x_reg     <= '0;
            pos_y_reg     <= '0;
            pos_z_reg     <= '0;
            dir_u_reg     <= '0;
            dir_v_reg     <= '0;
            dir_w_reg     <= 32'(prwht_pkg::ONE_Q30);
            weight_reg    <= prwht_pkg::ONE_Q30;
            albedo_reg    <= prwht_pkg::ALBEDO_RST;
            shells_reg    <= prwht_pkg::SHELLS_RST;
            threshold_reg <= prwht_pkg::THRESHOLD_RST;
            chance_reg    <= prwht_pkg::CHANCE_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            pos_x_reg     <= pos_x_next;
            pos_y_reg     <= pos_y_next;
            pos_z_reg     <= pos_z_next;
            dir_u_reg     <= dir_u_next;
            dir_v_reg     <= dir_v_next;
            dir_w_reg     <= dir_w_next;
            weight_reg    <= weight_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    prwht_pkg::REG_ALBEDO:    albedo_reg    <= cfg_wdata[23:0];
                    prwht_pkg::REG_SHELLS:    shells_reg    <= cfg_wdata[23:0];
                    prwht_pkg::REG_THRESHOLD: threshold_reg <= cfg_wdata;
                    default:                  chance_reg    <= cfg_wdata[15:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        rc_reg         <= rc_next;
        bin_reg        <= bin_next;
        e_reg          <= e_next;
        y_reg          <= y_next;
        frac_reg       <= frac_next;
        t_reg          <= t_next;
        acc_reg        <= acc_next;
        nw_reg         <= nw_next;
        x1_reg         <= x1_next;
        x2_reg         <= x2_next;
        s_reg          <= s_next;
        root_reg       <= root_next;
        shell_reg      <= shell_next;
        res_status_reg <= res_status_next;
        res_shell_reg  <= res_shell_next;
        res_bin_reg    <= res_bin_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_shell_reg  <= res_shell_reg;
            out_bin_reg    <= res_bin_reg;
            out_weight_reg <= weight_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = {2'b0, out_weight_reg, out_bin_reg, out_shell_reg};

endmodule
